// ----- hdl/lzrw1d_pkg.sv -----
// ----------------------------------------------------------------------------
// lzrw1d_pkg
// Shared types and constants of the LZRW1 stream decompressor: status codes,
// history window size and the command that the parser hands to the executor.
// ----------------------------------------------------------------------------
package lzrw1d_pkg;

    localparam int WIN_DEPTH = 4096;
    localparam int WIN_AW    = 12;

    // produced byte count saturates at the window size
    localparam logic [12:0] WIN_SIZE = 13'd4096;

    // items covered by one control word
    localparam logic [4:0] CTRL_ITEMS = 5'd16;

    // mode selector found in the first header byte
    localparam logic [7:0] RAW_MODE_MARK = 8'h01;

    localparam logic [1:0] ST_DATA       = 2'd0;
    localparam logic [1:0] ST_EMPTY      = 2'd1;
    localparam logic [1:0] ST_BAD_OFFSET = 2'd2;
    localparam logic [1:0] ST_TRUNC      = 2'd3;

    typedef enum logic [1:0] {
        KIND_RAW  = 2'd0,
        KIND_LIT  = 2'd1,
        KIND_COPY = 2'd2,
        KIND_STAT = 2'd3
    } kind_t;

    // data holds the byte for raw and literal beats, the status code for
    // status beats
    typedef struct packed {
        kind_t              kind;
        logic [7:0]         data;
        logic [WIN_AW-1:0]  offset;
        logic [3:0]         len_m1;
        logic               last;
    } cmd_t;

endpackage

// ----- hdl/lzrw1d_ram.sv -----
// ----------------------------------------------------------------------------
// lzrw1d_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is enabled.
// ----------------------------------------------------------------------------
module lzrw1d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hdl/lzrw1d_front.sv -----
// ----------------------------------------------------------------------------
// lzrw1d_front
// Stream parser: walks the header, control words and item bytes, checks copy
// offsets against the bytes produced so far and pushes one command for every
// input beat that causes output.
// ----------------------------------------------------------------------------
module lzrw1d_front #(
    parameter int HEADER_BYTES = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic                s_tlast,
    input  logic                q_full,
    output logic                push,
    output lzrw1d_pkg::cmd_t    push_cmd
);

    localparam int HC_W = $clog2(HEADER_BYTES + 1);

    typedef enum logic [3:0] {
        PH_CTRL_LO = 4'b0001,
        PH_CTRL_HI = 4'b0010,
        PH_ITEM    = 4'b0100,
        PH_COPY2   = 4'b1000
    } phase_t;

    logic [HC_W-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic            raw_mode_reg, raw_mode_next;
    phase_t          phase_reg, phase_next;
    logic [15:0]     ctrl_word_reg, ctrl_word_next;
    logic [4:0]      ctrl_left_reg, ctrl_left_next;
    logic [7:0]      item_byte_reg, item_byte_next;
    logic [12:0]     produced_reg, produced_next;

    logic                      accept;
    logic                      has_result;
    logic                      trunc;
    logic [lzrw1d_pkg::WIN_AW-1:0] offset;
    logic [4:0]                copy_len;
    logic [12:0]               sum_lit;
    logic [12:0]               sum_copy;
    logic [4:0]                left_dec;
    lzrw1d_pkg::cmd_t          cmd;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    assign offset   = {item_byte_reg[7:4], s_tdata};
    assign copy_len = {1'b0, item_byte_reg[3:0]} + 5'd1;
    assign sum_lit  = produced_reg + 13'd1;
    assign sum_copy = produced_reg + {8'd0, copy_len};
    assign left_dec = (ctrl_left_reg != 5'd0) ? ctrl_left_reg - 5'd1 : ctrl_left_reg;

    always_comb
    begin
        hdr_cnt_next   = hdr_cnt_reg;
        raw_mode_next  = raw_mode_reg;
        phase_next     = phase_reg;
        ctrl_word_next = ctrl_word_reg;
        ctrl_left_next = ctrl_left_reg;
        item_byte_next = item_byte_reg;
        produced_next  = produced_reg;
        has_result     = 1'b0;
        trunc          = 1'b0;
        cmd            = '0;
        cmd.kind       = lzrw1d_pkg::KIND_LIT;
        cmd.data       = s_tdata;
        cmd.offset     = offset;
        cmd.len_m1     = item_byte_reg[3:0];
        cmd.last       = s_tlast;

        if (hdr_cnt_reg < HC_W'(HEADER_BYTES))
        begin
            if (hdr_cnt_reg == '0)
            begin
                raw_mode_next = (s_tdata == lzrw1d_pkg::RAW_MODE_MARK);
            end
            hdr_cnt_next = hdr_cnt_reg + HC_W'(1);
            trunc        = (hdr_cnt_next < HC_W'(HEADER_BYTES));
        end
        else if (raw_mode_reg)
        begin
            has_result = 1'b1;
            cmd.kind   = lzrw1d_pkg::KIND_RAW;
        end
        else
        begin
            case (phase_reg)
                PH_CTRL_LO:
                begin
                    ctrl_word_next = {8'd0, s_tdata};
                    phase_next     = PH_CTRL_HI;
                    trunc          = 1'b1;
                end
                PH_CTRL_HI:
                begin
                    ctrl_word_next = {s_tdata, ctrl_word_reg[7:0]};
                    ctrl_left_next = lzrw1d_pkg::CTRL_ITEMS;
                    phase_next     = PH_ITEM;
                    trunc          = 1'b1;
                end
                PH_ITEM:
                begin
                    if (ctrl_word_reg[0])
                    begin
                        item_byte_next = s_tdata;
                        phase_next     = PH_COPY2;
                        trunc          = 1'b1;
                    end
                    else
                    begin
                        has_result     = 1'b1;
                        cmd.kind       = lzrw1d_pkg::KIND_LIT;
                        produced_next  = (sum_lit > lzrw1d_pkg::WIN_SIZE) ?
                                         lzrw1d_pkg::WIN_SIZE : sum_lit;
                        ctrl_word_next = {1'b0, ctrl_word_reg[15:1]};
                        ctrl_left_next = left_dec;
                        phase_next     = (left_dec != 5'd0) ? PH_ITEM : PH_CTRL_LO;
                    end
                end
                PH_COPY2:
                begin
                    has_result = 1'b1;
                    if (offset == '0 || {1'b0, offset} > produced_reg)
                    begin
                        cmd.kind = lzrw1d_pkg::KIND_STAT;
                        cmd.data = {6'd0, lzrw1d_pkg::ST_BAD_OFFSET};
                    end
                    else
                    begin
                        cmd.kind      = lzrw1d_pkg::KIND_COPY;
                        produced_next = (sum_copy > lzrw1d_pkg::WIN_SIZE) ?
                                        lzrw1d_pkg::WIN_SIZE : sum_copy;
                    end
                    ctrl_word_next = {1'b0, ctrl_word_reg[15:1]};
                    ctrl_left_next = left_dec;
                    phase_next     = (left_dec != 5'd0) ? PH_ITEM : PH_CTRL_LO;
                end
                default:
                begin
                    phase_next = PH_CTRL_LO;
                end
            endcase
        end

        // a final beat with no output of its own still reports a status
        if (s_tlast && !has_result)
        begin
            cmd.kind = lzrw1d_pkg::KIND_STAT;
            cmd.data = {6'd0, trunc ? lzrw1d_pkg::ST_TRUNC : lzrw1d_pkg::ST_EMPTY};
        end

        // end of stream: return to the initial parse state
        if (s_tlast)
        begin
            hdr_cnt_next   = '0;
            raw_mode_next  = 1'b0;
            phase_next     = PH_CTRL_LO;
            ctrl_word_next = '0;
            ctrl_left_next = '0;
            item_byte_next = '0;
            produced_next  = '0;
        end
    end

    assign push     = accept && (has_result || s_tlast);
    assign push_cmd = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_cnt_reg   <= '0;
            raw_mode_reg  <= 1'b0;
            phase_reg     <= PH_CTRL_LO;
            ctrl_word_reg <= '0;
            ctrl_left_reg <= '0;
            item_byte_reg <= '0;
            produced_reg  <= '0;
        end
        else if (accept)
        begin
            hdr_cnt_reg   <= hdr_cnt_next;
            raw_mode_reg  <= raw_mode_next;
            phase_reg     <= phase_next;
            ctrl_word_reg <= ctrl_word_next;
            ctrl_left_reg <= ctrl_left_next;
            item_byte_reg <= item_byte_next;
            produced_reg  <= produced_next;
        end
    end

endmodule

// ----- hdl/lzrw1d_queue.sv -----
// ----------------------------------------------------------------------------
// lzrw1d_queue
// Short command FIFO between parser and executor so that each side can stall
// on its own.
// ----------------------------------------------------------------------------
module lzrw1d_queue #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lzrw1d_pkg::cmd_t    push_cmd,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output lzrw1d_pkg::cmd_t    head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    lzrw1d_pkg::cmd_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("command pushed into a full queue");

endmodule

// ----- hdl/lzrw1d_back.sv -----
// ----------------------------------------------------------------------------
// lzrw1d_back
// Command executor: expands copies into single bytes, keeps the history
// window in RAM and drives the output register.
// ----------------------------------------------------------------------------
module lzrw1d_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  lzrw1d_pkg::cmd_t    head,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic [2:0]          m_tuser,
    output logic                m_tlast
);

    localparam int AW = lzrw1d_pkg::WIN_AW;

    logic [3:0]    cnt_reg, cnt_next;
    logic [AW-1:0] ip_reg, ip_next;

    logic                  pend_valid_reg;
    lzrw1d_pkg::kind_t     pend_kind_reg;
    logic [7:0]            pend_data_reg;
    logic                  pend_use_last_reg;
    logic [AW-1:0]         pend_addr_reg;
    logic                  pend_run_last_reg;
    logic                  pend_end_reg;
    logic [7:0]            last_byte_reg;

    logic                  out_valid_reg;
    logic [7:0]            out_byte_reg;
    logic [1:0]            out_status_reg;
    logic                  out_last_reg;
    logic                  out_end_reg;

    logic          pend_move;
    logic          issue;
    logic          is_copy;
    logic          writes_hist;
    logic          final_beat;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic          wr_en;
    logic [7:0]    pend_byte;
    logic          pend_is_stat;

    assign pend_move   = pend_valid_reg && (!out_valid_reg || m_tready);
    assign issue       = !q_empty && (!pend_valid_reg || pend_move);
    assign is_copy     = (head.kind == lzrw1d_pkg::KIND_COPY);
    assign writes_hist = is_copy || (head.kind == lzrw1d_pkg::KIND_LIT);
    assign final_beat  = !is_copy || (cnt_reg == head.len_m1);
    assign pop         = issue && final_beat;

    // offset one repeats the byte just written; skip the RAM for it
    assign rd_en   = issue && is_copy && (head.offset != AW'(1));
    assign rd_addr = ip_reg - head.offset;

    always_comb
    begin
        ip_next  = ip_reg;
        cnt_next = cnt_reg;
        if (issue)
        begin
            cnt_next = final_beat ? 4'd0 : cnt_reg + 4'd1;
            if (final_beat && head.last)
            begin
                ip_next = '0;
            end
            else if (writes_hist)
            begin
                ip_next = ip_reg + AW'(1);
            end
        end
    end

    assign pend_is_stat = (pend_kind_reg == lzrw1d_pkg::KIND_STAT);

    always_comb
    begin
        if (pend_kind_reg == lzrw1d_pkg::KIND_COPY)
        begin
            pend_byte = pend_use_last_reg ? last_byte_reg : rd_data;
        end
        else
        begin
            pend_byte = pend_data_reg;
        end
    end

    assign wr_en = pend_move && ((pend_kind_reg == lzrw1d_pkg::KIND_LIT) ||
                                 (pend_kind_reg == lzrw1d_pkg::KIND_COPY));

    lzrw1d_ram #(
        .WIDTH (8),
        .DEPTH (lzrw1d_pkg::WIN_DEPTH)
    ) u_history (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (pend_addr_reg),
        .wr_data (pend_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            ip_reg         <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ip_reg  <= ip_next;
            if (issue)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (pend_move)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (pend_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            pend_kind_reg     <= head.kind;
            pend_data_reg     <= head.data;
            pend_use_last_reg <= (head.offset == AW'(1));
            pend_addr_reg     <= ip_reg;
            pend_run_last_reg <= final_beat;
            pend_end_reg      <= final_beat && head.last;
        end
        if (wr_en)
        begin
            last_byte_reg <= pend_byte;
        end
        if (pend_move)
        begin
            out_byte_reg   <= pend_is_stat ? 8'd0 : pend_byte;
            out_status_reg <= pend_is_stat ? pend_data_reg[1:0] : lzrw1d_pkg::ST_DATA;
            out_last_reg   <= pend_run_last_reg;
            out_end_reg    <= pend_end_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_end_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && wr_en) |-> (rd_addr != pend_addr_reg))
        else $error("history read collides with write");

    a_copy_offset_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && is_copy) |-> (head.offset != '0))
        else $error("copy command with zero offset");

    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_end_reg) |-> out_last_reg)
        else $error("stream end without run end");

    a_status_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != lzrw1d_pkg::ST_DATA)) |-> (out_byte_reg == 8'd0))
        else $error("status beat carries data");

endmodule

// ----- hdl/lzrw1_stream_decompressor_core.sv -----
// ----------------------------------------------------------------------------
// lzrw1_stream_decompressor_core
// LZRW1 stream decompressor: one compressed byte per input beat, one
// decompressed byte or status per output beat.
// A result passes through the command queue, the executor's pending register and
// the output register on its way out.
// Throughput: one input beat per cycle for header, control and literal bytes;
// a copy emits up to 16 bytes, one per cycle while the output is not stalled,
// set by the executor walking the history RAM; input stalls once the queue fills.
// Reset clears all parser and executor control state; the history RAM is not
// cleared, since reads stay within the bytes written in the current stream.
// ----------------------------------------------------------------------------
module lzrw1_stream_decompressor_core #(
    parameter int HEADER_BYTES = 4,
    parameter int QUEUE_DEPTH  = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // end_flag
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [2:0] m_tuser,   // [1:0] status, [2] stream_end
    output logic       m_tlast    // run_last
);

    logic             q_full;
    logic             q_empty;
    logic             push;
    logic             pop;
    lzrw1d_pkg::cmd_t push_cmd;
    lzrw1d_pkg::cmd_t head;

    lzrw1d_front #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    lzrw1d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head     (head)
    );

    lzrw1d_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- tb/sv/lzrw1_stream_decompressor_core_test.sv -----
// ----------------------------------------------------------------------------
// lzrw1_stream_decompressor_core_test
// Self-checking bench for the LZRW1 stream decompressor. A short table of
// hand-written streams comes first, then random raw, compressed and garbage
// streams.
// A byte-level decoder in the bench predicts the beats of random and CHK_PRED rows;
// CHK_ONE rows carry theirs. Each beat taken from the block is compared in order.
// ----------------------------------------------------------------------------
module lzrw1_stream_decompressor_core_test;

    import lzrw1d_pkg::*;

    localparam int HDR_BYTES   = 4;
    localparam int RAND_ITEMS  = 230;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 16;
    localparam int MAX_PRINTS  = 30;

    typedef enum logic [1:0] {
        PH_CTRL_LO = 2'd0,
        PH_CTRL_HI = 2'd1,
        PH_ITEM    = 2'd2,
        PH_COPY2   = 2'd3
    } phase_t;

    // how a stimulus row is checked
    typedef enum logic [1:0] {
        CHK_PRED = 2'd0,
        CHK_NONE = 2'd1,
        CHK_ONE  = 2'd2
    } chk_t;

    typedef enum logic [1:0] {
        END_CLEAN   = 2'd0,
        END_AT_CTRL = 2'd1,
        END_IN_COPY = 2'd2
    } end_mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] status;
        logic       run_last;
        logic       stream_end;
    } result_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       fin;
        chk_t       chk;
        result_t    want;
    } beat_t;

    localparam result_t NO_RES = '{8'h00, ST_DATA, 1'b0, 1'b0};

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;
    logic       m_tlast;

    lzrw1_stream_decompressor_core #(
        .HEADER_BYTES(HDR_BYTES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hand-written streams: header cut, raw, empty end, literals and copies
    beat_t dir_tab [25] = '{
        '{8'h01, 1'b1, CHK_ONE,  '{8'h00, ST_TRUNC,      1'b1, 1'b1}},
        '{8'h01, 1'b0, CHK_NONE, NO_RES},
        '{8'h00, 1'b0, CHK_NONE, NO_RES},
        '{8'h00, 1'b0, CHK_NONE, NO_RES},
        '{8'hFF, 1'b0, CHK_NONE, NO_RES},
        '{8'h00, 1'b0, CHK_ONE,  '{8'h00, ST_DATA,       1'b1, 1'b0}},
        '{8'hFF, 1'b1, CHK_ONE,  '{8'hFF, ST_DATA,       1'b1, 1'b1}},
        '{8'h00, 1'b0, CHK_NONE, NO_RES},
        '{8'h11, 1'b0, CHK_NONE, NO_RES},
        '{8'h22, 1'b0, CHK_NONE, NO_RES},
        '{8'h33, 1'b1, CHK_ONE,  '{8'h00, ST_EMPTY,      1'b1, 1'b1}},
        '{8'hFF, 1'b0, CHK_NONE, NO_RES},
        '{8'h00, 1'b0, CHK_NONE, NO_RES},
        '{8'h00, 1'b0, CHK_NONE, NO_RES},
        '{8'h00, 1'b0, CHK_NONE, NO_RES},
        '{8'h0E, 1'b0, CHK_NONE, NO_RES},
        '{8'h80, 1'b0, CHK_NONE, NO_RES},
        '{8'hAB, 1'b0, CHK_ONE,  '{8'hAB, ST_DATA,       1'b1, 1'b0}},
        '{8'h00, 1'b0, CHK_NONE, NO_RES},
        '{8'h00, 1'b0, CHK_ONE,  '{8'h00, ST_BAD_OFFSET, 1'b1, 1'b0}},
        '{8'h0F, 1'b0, CHK_PRED, NO_RES},
        '{8'h01, 1'b0, CHK_PRED, NO_RES},
        '{8'hF0, 1'b0, CHK_NONE, NO_RES},
        '{8'hFF, 1'b0, CHK_ONE,  '{8'h00, ST_BAD_OFFSET, 1'b1, 1'b0}},
        '{8'h7F, 1'b1, CHK_ONE,  '{8'h7F, ST_DATA,       1'b1, 1'b1}}
    };

    // decoder state
    int          hdr_cnt;
    logic        raw_sel;
    phase_t      phase;
    logic [15:0] ctrl_word;
    logic [4:0]  ctrl_left;
    logic [7:0]  copy_head;
    logic [11:0] wr_ptr;
    logic [12:0] produced;
    logic [7:0]  history [WIN_DEPTH];

    result_t     step_out[$];
    result_t     decoded_q[$];
    beat_t       stream_q[$];
    beat_t       inflight_q[$];

    int          err_count;
    int          out_count;
    int          idle_cycles;
    int          burst_left;
    logic [7:0]  ready_pat;
    int          pat_pos;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < MAX_PRINTS)
            $display("mismatch at output beat %0d: %s got %0h, wanted %0h",
                     out_count, what, got, want);
        err_count++;
    endtask

    function automatic void emit_result(input logic [7:0] data, input logic [1:0] st);
        step_out.push_back('{data, st, 1'b0, 1'b0});
    endfunction

    function automatic void store_byte(input logic [7:0] data);
        history[wr_ptr] = data;
        wr_ptr++;
        if (produced < WIN_SIZE)
            produced++;
        emit_result(data, ST_DATA);
    endfunction

    function automatic void next_item();
        ctrl_word = ctrl_word >> 1;
        if (ctrl_left != 0)
            ctrl_left--;
        phase = (ctrl_left != 0) ? PH_ITEM : PH_CTRL_LO;
    endfunction

    function automatic void clear_stream();
        hdr_cnt   = 0;
        raw_sel   = 1'b0;
        phase     = PH_CTRL_LO;
        ctrl_word = '0;
        ctrl_left = '0;
        copy_head = '0;
        wr_ptr    = '0;
        produced  = '0;
    endfunction

    // decode one accepted byte into step_out
    task automatic decode_beat(input logic [7:0] b, input logic fin);
        logic        trunc;
        logic [11:0] off;
        logic [11:0] src;
        int          len;
        result_t     tail;
        step_out.delete();
        trunc = 1'b0;
        if (hdr_cnt < HDR_BYTES)
        begin
            if (hdr_cnt == 0)
                raw_sel = (b == RAW_MODE_MARK);
            hdr_cnt++;
            trunc = (hdr_cnt < HDR_BYTES);
        end
        else if (raw_sel)
            emit_result(b, ST_DATA);
        else
        begin
            case (phase)
                PH_CTRL_LO:
                begin
                    ctrl_word = {8'h00, b};
                    phase = PH_CTRL_HI;
                    trunc = 1'b1;
                end
                PH_CTRL_HI:
                begin
                    ctrl_word[15:8] = b;
                    ctrl_left = CTRL_ITEMS;
                    phase = PH_ITEM;
                    trunc = 1'b1;
                end
                PH_ITEM:
                begin
                    if (ctrl_word[0])
                    begin
                        copy_head = b;
                        phase = PH_COPY2;
                        trunc = 1'b1;
                    end
                    else
                    begin
                        store_byte(b);
                        next_item();
                    end
                end
                default:
                begin
                    off = {copy_head[7:4], b};
                    len = int'(copy_head[3:0]) + 1;
                    if (off == 0 || {1'b0, off} > produced)
                        emit_result(8'h00, ST_BAD_OFFSET);
                    else
                        for (int i = 0; i < len; i++)
                        begin
                            // read one byte at a time so overlapping copies repeat
                            src = wr_ptr - off;
                            store_byte(history[src]);
                        end
                    next_item();
                end
            endcase
        end
        if (fin)
        begin
            if (trunc)
                emit_result(8'h00, ST_TRUNC);
            else if (step_out.size() == 0)
                emit_result(8'h00, ST_EMPTY);
        end
        if (step_out.size() != 0)
        begin
            tail = step_out.pop_back();
            tail.run_last = 1'b1;
            tail.stream_end = fin;
            step_out.push_back(tail);
        end
        if (fin)
            clear_stream();
    endtask

    function automatic void push_beat(input logic [7:0] b, input logic fin);
        stream_q.push_back('{b, fin, CHK_PRED, NO_RES});
    endfunction

    task automatic gen_compressed(input logic long_run);
        int          groups;
        int          n_items;
        int          prod;
        int          cap;
        int          ofs;
        end_mode_t   end_mode;
        logic [15:0] ctrl;
        logic [3:0]  len_m1;
        logic [7:0]  hb;
        logic        lastg;
        logic        tail;
        prod = 0;
        do
            hb = 8'($urandom);
        while (hb == RAW_MODE_MARK);
        push_beat(hb, 1'b0);
        repeat (HDR_BYTES - 1) push_beat(8'($urandom), 1'b0);
        groups = long_run ? 18 : $urandom_range(1, 3);
        case ($urandom_range(0, 3))
            2:       end_mode = END_AT_CTRL;
            3:       end_mode = END_IN_COPY;
            default: end_mode = END_CLEAN;
        endcase
        if (long_run)
            end_mode = END_CLEAN;
        for (int g = 0; g < groups; g++)
        begin
            lastg = (g == groups - 1);
            n_items = 16;
            if (lastg && !long_run)
                n_items = (end_mode == END_AT_CTRL) ? 0 : $urandom_range(1, 16);
            if (long_run)
                ctrl = (g == 0) ? 16'hFFFE : 16'hFFFF;
            else
                case ($urandom_range(0, 3))
                    0:       ctrl = 16'h0000;
                    1:       ctrl = 16'hFFFF;
                    default: ctrl = 16'($urandom);
                endcase
            if (lastg && end_mode == END_IN_COPY)
                ctrl[n_items - 1] = 1'b1;
            // cut right after the low control byte
            if (n_items == 0 && $urandom_range(0, 1) == 0)
            begin
                push_beat(ctrl[7:0], 1'b1);
                return;
            end
            push_beat(ctrl[7:0], 1'b0);
            push_beat(ctrl[15:8], n_items == 0);
            for (int i = 0; i < n_items; i++)
            begin
                tail = lastg && (i == n_items - 1);
                if (!ctrl[i])
                begin
                    push_beat(8'($urandom), tail);
                    if (prod < 4096)
                        prod++;
                end
                else
                begin
                    len_m1 = long_run ? 4'hF : 4'($urandom);
                    cap = (prod > 4095) ? 4095 : prod;
                    if (cap == 0 || (!long_run && $urandom_range(0, 9) == 0))
                    begin
                        case ($urandom_range(0, 2))
                            0:       ofs = 0;
                            1:       ofs = (cap < 4095) ? cap + 1 : 0;
                            default: ofs = (cap < 4095) ? $urandom_range(cap + 1, 4095) : 0;
                        endcase
                    end
                    else
                    begin
                        ofs = $urandom_range(1, cap);
                        // short offsets make the copy overlap its own output
                        if ($urandom_range(0, 3) == 0)
                            ofs = (cap < 3) ? cap : $urandom_range(1, 3);
                        if (cap == 4095 && $urandom_range(0, 3) == 0)
                            ofs = 4095;
                        prod = prod + int'(len_m1) + 1;
                        if (prod > 4096)
                            prod = 4096;
                    end
                    push_beat({4'(ofs >> 8), len_m1}, tail && end_mode == END_IN_COPY);
                    if (tail && end_mode == END_IN_COPY)
                        return;
                    push_beat(8'(ofs), tail);
                end
            end
        end
    endtask

    task automatic gen_raw();
        int n_body;
        int cut;
        if ($urandom_range(0, 5) == 0)
        begin
            // end inside the header
            cut = $urandom_range(1, HDR_BYTES - 1);
            push_beat(RAW_MODE_MARK, cut == 1);
            for (int i = 1; i < cut; i++)
                push_beat(8'($urandom), i == cut - 1);
            return;
        end
        n_body = $urandom_range(0, 20);
        push_beat(RAW_MODE_MARK, 1'b0);
        for (int i = 1; i < HDR_BYTES; i++)
            push_beat(8'($urandom), n_body == 0 && i == HDR_BYTES - 1);
        for (int i = 0; i < n_body; i++)
            push_beat(8'($urandom), i == n_body - 1);
    endtask

    task automatic gen_noise();
        int n;
        n = $urandom_range(1, 30);
        for (int i = 0; i < n; i++)
            push_beat(8'($urandom), (i == n - 1) || ($urandom_range(0, 9) == 0));
    endtask

    // present one beat, hold until taken, then maybe open a gap
    task automatic send_item(input beat_t it);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= it.byte_in;
        s_tlast  <= it.fin;
        inflight_q.push_back(it);
        do
            @(posedge clk);
        while (!s_tready);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 48 : 8);
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_stream();
        while (stream_q.size() != 0)
            send_item(stream_q.pop_front());
    endtask

    // drop valid and hold until every predicted beat has come out
    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (decoded_q.size() != 0)
            @(posedge clk);
    endtask

    // input side: predict on acceptance, and watch for a hung block
    always @(posedge clk)
    begin
        beat_t it;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                it = inflight_q.pop_front();
                decode_beat(it.byte_in, it.fin);
                case (it.chk)
                    CHK_PRED: foreach (step_out[k]) decoded_q.push_back(step_out[k]);
                    CHK_ONE:  decoded_q.push_back(it.want);
                    default:  ;
                endcase
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // output side: compare every beat with the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (decoded_q.size() == 0)
                report_mismatch("beat with nothing pending", {m_tuser, m_tdata}, 0);
            else
            begin
                want = decoded_q.pop_front();
                if (m_tuser[1:0] !== want.status)
                    report_mismatch("status", m_tuser[1:0], want.status);
                if (m_tdata !== want.data)
                    report_mismatch("out_byte", m_tdata, want.data);
                if (m_tlast !== want.run_last)
                    report_mismatch("run_last", m_tlast, want.run_last);
                if (m_tuser[2] !== want.stream_end)
                    report_mismatch("stream_end", m_tuser[2], want.stream_end);
            end
            out_count++;
        end
    end

    // receiver stall pattern, reloaded each time pat_pos wraps to zero
    always @(posedge clk)
    begin
        if (pat_pos == 0)
            ready_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
        m_tready <= ready_pat[pat_pos % 8];
        pat_pos = (pat_pos + 1) % 64;
    end

    initial
    begin
        int rand_items;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        err_count   = 0;
        out_count   = 0;
        idle_cycles = 0;
        burst_left  = 0;
        rand_items  = 0;
        clear_stream();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_item(dir_tab[i]);
        drain_outputs();

        while (rand_items < RAND_ITEMS)
        begin
            case ($urandom_range(0, 9))
                6, 7:    gen_raw();
                8, 9:    gen_noise();
                default: gen_compressed(1'b0);
            endcase
            rand_items += stream_q.size();
            send_stream();
            if ($urandom_range(0, 5) == 0)
                drain_outputs();
        end

        drain_outputs();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
